[hdl/pfm_pkg.sv]
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared widths, lane codes, the bus between multiplier cells and the
// reduction helper for the POLYVAL field multiplier.
// ----------------------------------------------------------------------------
package pfm_pkg;

   localparam int HALF_WIDTH    = 64;
   localparam int FULL_WIDTH    = 2 * HALF_WIDTH;
   localparam int BITS_PER_CELL = 8;
   localparam int CELL_COUNT    = HALF_WIDTH / BITS_PER_CELL;

   // Karatsuba lanes
   localparam int LANE_COUNT = 3;
   localparam int LANE_LOW   = 0;
   localparam int LANE_HIGH  = 1;
   localparam int LANE_MID   = 2;

   // x operand pre-shifted by the bits already consumed, y operand still to
   // be consumed from bit 0 upward, partial carryless product so far
   typedef struct packed {
      logic [LANE_COUNT-1:0][FULL_WIDTH-1:0] x;
      logic [LANE_COUNT-1:0][HALF_WIDTH-1:0] y;
      logic [LANE_COUNT-1:0][FULL_WIDTH-1:0] acc;
   } cell_bus_type;

   // carryless product with 0xC200000000000000: terms at bits 63, 62 and 57
   function automatic logic [FULL_WIDTH-1:0] fold_mul(input logic [HALF_WIDTH-1:0] a);
      logic [FULL_WIDTH-1:0] wide;
      wide = {{HALF_WIDTH{1'b0}}, a};
      return (wide << 63) ^ (wide << 62) ^ (wide << 57);
   endfunction

endpackage

[hdl/pfm_cell.sv]
// ----------------------------------------------------------------------------
// pfm_cell
// One slice of the carryless multiplier chain: folds eight bits of each y
// lane into the partial products and passes the item on.
// ----------------------------------------------------------------------------
module pfm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pfm_pkg::cell_bus_type in_bus,
   output logic                  in_ready,
   output logic                  out_valid,
   output pfm_pkg::cell_bus_type out_bus,
   input  logic                  out_ready
);
   import pfm_pkg::*;

   logic         valid_ff, valid_in;
   cell_bus_type bus_ff, bus_in;
   logic         load;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_comb begin
      logic [FULL_WIDTH-1:0] acc;
      for (int k = 0; k < LANE_COUNT; k++) begin
         acc = in_bus.acc[k];
         for (int j = 0; j < BITS_PER_CELL; j++) begin
            if (in_bus.y[k][j]) begin
               acc = acc ^ (in_bus.x[k] << j);
            end
         end
         bus_in.acc[k] = acc;
         bus_in.x[k]   = in_bus.x[k] << BITS_PER_CELL;
         bus_in.y[k]   = in_bus.y[k] >> BITS_PER_CELL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bus_ff <= bus_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bus   = bus_ff;

   // held item survives a blocked neighbour
   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff)
      else $error("cell dropped a held item");

   a_hold_bus : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> $stable(bus_ff))
      else $error("cell item changed while held");

   // consumed x positions are always clear after the shift
   a_shift_clear : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bus_ff.x[LANE_LOW][BITS_PER_CELL-1:0] == '0) &&
                   (bus_ff.x[LANE_HIGH][BITS_PER_CELL-1:0] == '0) &&
                   (bus_ff.x[LANE_MID][BITS_PER_CELL-1:0] == '0))
      else $error("cell x shift left stale bits");

endmodule

[hdl/pfm_fold.sv]
// ----------------------------------------------------------------------------
// pfm_fold
// Karatsuba recombination and two-fold Montgomery reduction, ending in the
// result register.
// ----------------------------------------------------------------------------
module pfm_fold (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  pfm_pkg::cell_bus_type              in_bus,
   output logic                               in_ready,
   output logic                               rsp_valid,
   output logic [pfm_pkg::HALF_WIDTH-1:0]     rsp_z_low,
   output logic [pfm_pkg::HALF_WIDTH-1:0]     rsp_z_high,
   input  logic                               rsp_stall
);
   import pfm_pkg::*;

   logic                  valid_ff, valid_in;
   logic [HALF_WIDTH-1:0] z_low_ff, z_low_in, z_high_ff, z_high_in;
   logic [FULL_WIDTH-1:0] lo_p, hi_p, mid_p, fa, fc;
   logic [HALF_WIDTH-1:0] p0, p1, p2, p3, b_lo, b_hi;
   logic                  load;

   always_comb begin
      in_ready = !valid_ff || !rsp_stall;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_comb begin
      lo_p  = in_bus.acc[LANE_LOW];
      hi_p  = in_bus.acc[LANE_HIGH];
      mid_p = in_bus.acc[LANE_MID];

      p0 = lo_p[HALF_WIDTH-1:0];
      p1 = mid_p[HALF_WIDTH-1:0] ^ lo_p[FULL_WIDTH-1:HALF_WIDTH]
         ^ hi_p[HALF_WIDTH-1:0] ^ lo_p[HALF_WIDTH-1:0];
      p2 = mid_p[FULL_WIDTH-1:HALF_WIDTH] ^ hi_p[HALF_WIDTH-1:0]
         ^ hi_p[FULL_WIDTH-1:HALF_WIDTH] ^ lo_p[FULL_WIDTH-1:HALF_WIDTH];
      p3 = hi_p[FULL_WIDTH-1:HALF_WIDTH];

      fa   = fold_mul(p0);
      b_lo = p0 ^ fa[FULL_WIDTH-1:HALF_WIDTH];
      b_hi = p1 ^ fa[HALF_WIDTH-1:0];

      fc        = fold_mul(b_hi);
      z_low_in  = p2 ^ fc[HALF_WIDTH-1:0] ^ b_lo;
      z_high_in = p3 ^ fc[FULL_WIDTH-1:HALF_WIDTH] ^ b_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         z_low_ff  <= z_low_in;
         z_high_ff <= z_high_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_z_low  = z_low_ff;
   assign rsp_z_high = z_high_ff;

endmodule

[hdl/polyval_field_multiply.sv]
// ----------------------------------------------------------------------------
// polyval_field_multiply
// POLYVAL Montgomery multiply in GF(2^128): z = x * y * x^-128.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: req_valid / req_stall carry one item, the operands
//   x and y as 64-bit low and high halves (bit 0 of a low half is x^0).
//   Response channel: rsp_valid / rsp_stall carry z as z_low and z_high.
//   An item moves at an edge where valid is high and stall is low.
//
//   The pipe is eight multiplier cells, each folding eight bits of every
//   y lane into the three Karatsuba products, then one reduction stage
//   that also holds the result register.
//   Throughput is one item per cycle while rsp_stall is low, set by the cell
//   chain: every cell and the result register hands its item on each cycle.
//
//   Each stage loads whenever it is empty or its neighbour takes its item,
//   so empty slots in the chain keep taking items while a result waits.
//   With rsp_stall held, items pile up; req_stall rises only once every
//   stage is full.
//   Reset clears all valid flags; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module polyval_field_multiply (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pfm_pkg::HALF_WIDTH-1:0] req_x_low,
   input  logic [pfm_pkg::HALF_WIDTH-1:0] req_x_high,
   input  logic [pfm_pkg::HALF_WIDTH-1:0] req_y_low,
   input  logic [pfm_pkg::HALF_WIDTH-1:0] req_y_high,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pfm_pkg::HALF_WIDTH-1:0] rsp_z_low,
   output logic [pfm_pkg::HALF_WIDTH-1:0] rsp_z_high
);
   import pfm_pkg::*;

   // chain position 0 is the request port, CELL_COUNT feeds the reduction
   cell_bus_type          chain_bus   [CELL_COUNT+1];
   logic [CELL_COUNT:0]   chain_valid;
   logic [CELL_COUNT:0]   chain_ready;

   // operands widened to the product width; the middle lane takes the sums
   always_comb begin
      chain_valid[0]                = req_valid;
      chain_bus[0].x[LANE_LOW]      = {{HALF_WIDTH{1'b0}}, req_x_low};
      chain_bus[0].x[LANE_HIGH]     = {{HALF_WIDTH{1'b0}}, req_x_high};
      chain_bus[0].x[LANE_MID]      = {{HALF_WIDTH{1'b0}}, req_x_low ^ req_x_high};
      chain_bus[0].y[LANE_LOW]      = req_y_low;
      chain_bus[0].y[LANE_HIGH]     = req_y_high;
      chain_bus[0].y[LANE_MID]      = req_y_low ^ req_y_high;
      chain_bus[0].acc              = '0;
   end

   assign req_stall = !chain_ready[0];

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      pfm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_bus    (chain_bus[g]),
         .in_ready  (chain_ready[g]),
         .out_valid (chain_valid[g+1]),
         .out_bus   (chain_bus[g+1]),
         .out_ready (chain_ready[g+1])
      );
   end

   pfm_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[CELL_COUNT]),
      .in_bus     (chain_bus[CELL_COUNT]),
      .in_ready   (chain_ready[CELL_COUNT]),
      .rsp_valid  (rsp_valid),
      .rsp_z_low  (rsp_z_low),
      .rsp_z_high (rsp_z_high),
      .rsp_stall  (rsp_stall)
   );

   // back-pressure reaches the request side only with every stage full
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&chain_valid[CELL_COUNT:1]) && rsp_valid && rsp_stall)
      else $error("request stalled with room in the chain");

   // a free response side never blocks the request side
   a_no_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled with the response side free");

   // an item leaving the chain lands in the result register
   a_land : assert property (@(posedge clock) disable iff (reset)
      chain_valid[CELL_COUNT] && chain_ready[CELL_COUNT] |=> rsp_valid)
      else $error("item lost between chain and result register");

endmodule

[test/tb_polyval_field_multiply.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyval_field_multiply
// Self-checking bench for the POLYVAL Montgomery multiplier. A table of
// directed operands is followed by random operands in bursts. Every product
// is checked against a typed-in value or a bit-level model, with the
// receiver stalling on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_polyval_field_multiply;

   import pfm_pkg::*;

   typedef logic [HALF_WIDTH-1:0] half_type;

   // one expected product, held in arrival order
   typedef struct packed {
      half_type z_low;
      half_type z_high;
   } product_type;

   // directed row: operands, plus a product typed in where it is obvious
   typedef struct packed {
      half_type x_low;
      half_type x_high;
      half_type y_low;
      half_type y_high;
      logic     known;
      half_type z_low;
      half_type z_high;
   } op_row_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HEAVY,
      STALL_HOLD
   } stall_mode_type;

   // reduction constant, the same in both 64-bit halves of the fold
   localparam half_type MONT_FOLD    = 64'hC200_0000_0000_0000;
   localparam half_type ALL_ONES     = {HALF_WIDTH{1'b1}};
   localparam half_type ONE_BIT      = 64'h1;
   localparam int       RANDOM_ITEMS = 1300;
   localparam int       DRAIN_EVERY  = 400;
   localparam int       TAIL_CYCLES  = 40;
   localparam int       IDLE_LIMIT   = 2000;
   localparam int       DIR_ROWS     = 16;

   // x^128 mod P, i.e. the unit in Montgomery form: {high, low}
   localparam half_type MONT_ONE_LOW  = ONE_BIT;
   localparam half_type MONT_ONE_HIGH = MONT_FOLD;

   localparam op_row_type DIRECTED [0:DIR_ROWS-1] = '{
      // zero operands give zero
      '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h0, 64'h0},
      '{ALL_ONES, ALL_ONES, 64'h0, 64'h0, 1'b1, 64'h0, 64'h0},
      '{64'h0, 64'h0, ALL_ONES, ALL_ONES, 1'b1, 64'h0, 64'h0},
      '{64'h0, 64'h0, MONT_ONE_LOW, MONT_ONE_HIGH, 1'b1, 64'h0, 64'h0},
      // the Montgomery unit leaves the other operand untouched
      '{ONE_BIT, 64'h0, MONT_ONE_LOW, MONT_ONE_HIGH, 1'b1, ONE_BIT, 64'h0},
      '{ALL_ONES, ALL_ONES, MONT_ONE_LOW, MONT_ONE_HIGH, 1'b1, ALL_ONES, ALL_ONES},
      '{MONT_ONE_LOW, MONT_ONE_HIGH, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
        1'b1, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF},
      '{MONT_ONE_LOW, MONT_ONE_HIGH, MONT_ONE_LOW, MONT_ONE_HIGH,
        1'b1, MONT_ONE_LOW, MONT_ONE_HIGH},
      // the rest against the model
      '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 64'h0, 64'h0},
      '{ONE_BIT, 64'h0, ONE_BIT, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h8000_0000_0000_0000, 64'h0, 64'h0, ONE_BIT, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000,
        1'b0, 64'h0, 64'h0},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 64'h0},
      '{ALL_ONES, 64'h0, 64'h0, ALL_ONES, 1'b0, 64'h0, 64'h0},
      '{64'h0, ALL_ONES, ALL_ONES, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h0F0F_0F0F_F0F0_F0F0, 64'h3C3C_C3C3_3C3C_C3C3,
        64'hDEAD_BEEF_0BAD_F00D, 64'h8000_0000_0000_0001, 1'b0, 64'h0, 64'h0}
   };

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_valid  = 1'b0;
   logic     req_stall;
   half_type req_x_low  = '0;
   half_type req_x_high = '0;
   half_type req_y_low  = '0;
   half_type req_y_high = '0;
   logic     rsp_valid;
   logic     rsp_stall  = 1'b0;
   half_type rsp_z_low;
   half_type rsp_z_high;

   // typed-in product travelling alongside the payload of the item on offer
   logic     offer_known  = 1'b0;
   half_type offer_z_low  = '0;
   half_type offer_z_high = '0;

   product_type    products_due [$];
   int             mismatches  = 0;
   int             burst_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_left  = 0;

   always #6 clock = ~clock;

   polyval_field_multiply u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_x_low  (req_x_low),
      .req_x_high (req_x_high),
      .req_y_low  (req_y_low),
      .req_y_high (req_y_high),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_z_low  (rsp_z_low),
      .rsp_z_high (rsp_z_high)
   );

   // 64x64 carryless multiply
   function automatic logic [FULL_WIDTH-1:0] clmul_half(input half_type a, input half_type b);
      logic [FULL_WIDTH-1:0] r;
      r = '0;
      for (int i = 0; i < HALF_WIDTH; i++) begin
         if (b[i]) begin
            r ^= {{HALF_WIDTH{1'b0}}, a} << i;
         end
      end
      return r;
   endfunction

   // Schoolbook 256-bit carryless product (equal to the Karatsuba form),
   // then the two Montgomery folds.
   function automatic product_type polyval_product(input half_type xl, input half_type xh,
                                                   input half_type yl, input half_type yh);
      logic [2*FULL_WIDTH-1:0] wide;
      logic [FULL_WIDTH-1:0]   xw;
      logic [FULL_WIDTH-1:0]   yw;
      logic [FULL_WIDTH-1:0]   fold_a;
      logic [FULL_WIDTH-1:0]   fold_c;
      half_type                p0, p1, p2, p3;
      half_type                b_lo, b_hi;
      product_type             z;
      xw   = {xh, xl};
      yw   = {yh, yl};
      wide = '0;
      for (int i = 0; i < FULL_WIDTH; i++) begin
         if (yw[i]) begin
            wide ^= {{FULL_WIDTH{1'b0}}, xw} << i;
         end
      end
      {p3, p2, p1, p0} = wide;
      // first fold clears p0 into the middle words
      fold_a = clmul_half(p0, MONT_FOLD);
      b_lo   = p0 ^ fold_a[FULL_WIDTH-1:HALF_WIDTH];
      b_hi   = p1 ^ fold_a[HALF_WIDTH-1:0];
      // second fold clears b_hi
      fold_c   = clmul_half(b_hi, MONT_FOLD);
      z.z_low  = p2 ^ fold_c[HALF_WIDTH-1:0] ^ b_lo;
      z.z_high = p3 ^ fold_c[FULL_WIDTH-1:HALF_WIDTH] ^ b_hi;
      return z;
   endfunction

   // operand half drawn from a few shapes; mostly dense random
   function automatic half_type random_half();
      half_type v;
      case ($urandom_range(0, 15))
         0:       v = '0;
         1:       v = ALL_ONES;
         2:       v = ONE_BIT << $urandom_range(0, HALF_WIDTH - 1);
         3:       v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         4:       v = {$urandom, $urandom} | {$urandom, $urandom};
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // offer one item and hold it until it is taken
   task automatic offer_operands(input half_type xl, input half_type xh, input half_type yl,
                                 input half_type yh, input logic known,
                                 input half_type zl, input half_type zh);
      req_valid    <= 1'b1;
      req_x_low    <= xl;
      req_x_high   <= xh;
      req_y_low    <= yl;
      req_y_high   <= yh;
      offer_known  <= known;
      offer_z_low  <= zl;
      offer_z_high <= zh;
      do @(posedge clock); while (req_stall);
   endtask

   // burst pacing: gaps only between bursts, some bursts long and unbroken
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 24);
      end
   endtask

   // sender holds off until every product on its way has been seen
   task automatic drain_products();
      req_valid <= 1'b0;
      @(posedge clock);
      while (products_due.size() != 0) @(posedge clock);
   endtask

   task automatic offer_random();
      half_type xl, xh, yl, yh;
      xl = random_half();
      xh = random_half();
      yl = random_half();
      yh = random_half();
      // now and then the Montgomery unit on one side
      if ($urandom_range(0, 31) == 0) begin
         yl = MONT_ONE_LOW;
         yh = MONT_ONE_HIGH;
      end
      offer_operands(xl, xh, yl, yh, 1'b0, '0, '0);
   endtask

   // accepted item: queue the typed product or the model's one
   always @(posedge clock) begin : record_operands
      product_type p;
      if (!reset && req_valid && !req_stall) begin
         if (offer_known) begin
            p.z_low  = offer_z_low;
            p.z_high = offer_z_high;
         end else begin
            p = polyval_product(req_x_low, req_x_high, req_y_low, req_y_high);
         end
         products_due.push_back(p);
      end
   end

   // accepted result against the oldest product due
   always @(posedge clock) begin : check_product
      product_type p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (products_due.size() == 0) begin
            $error("unexpected result z_low=%h z_high=%h", rsp_z_low, rsp_z_high);
            mismatches++;
         end else begin
            p = products_due.pop_front();
            if (rsp_z_low !== p.z_low) begin
               $error("z_low: expected %h, got %h", p.z_low, rsp_z_low);
               mismatches++;
            end
            if (rsp_z_high !== p.z_high) begin
               $error("z_high: expected %h, got %h", p.z_high, rsp_z_high);
               mismatches++;
            end
         end
      end
   end

   // receiver back-pressure: free flow, light, heavy and solid stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(2, 30)
                                                    : $urandom_range(20, 150);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            default:      rsp_stall <= 1'b1;
         endcase
      end
   end

   // watchdog: too long with nothing moving on either channel
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         offer_operands(DIRECTED[r].x_low, DIRECTED[r].x_high, DIRECTED[r].y_low,
                        DIRECTED[r].y_high, DIRECTED[r].known,
                        DIRECTED[r].z_low, DIRECTED[r].z_high);
         pace_sender();
      end
      drain_products();

      // random operands, with a full drain every so often
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            drain_products();
         end
         offer_random();
         pace_sender();
      end

      drain_products();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && products_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
